[hw/rtl/aafs_pkg.sv]
`timescale 1ns / 1ps

package aafs_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;

    localparam logic [CFG_W-1:0] ENGAGE_LIMIT_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] RETRACT_LIMIT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] PAUSE_TICKS_RST   = 16'd500;
    localparam logic             FIRE_HOLD_RST     = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_ENGAGE   = 3'd1,
        ST_PAUSE    = 3'd2,
        ST_PULLBACK = 3'd3,
        ST_ARMED    = 3'd4,
        ST_FIRING   = 3'd5,
        ST_HOLD     = 3'd6
    } seq_state_t;

    localparam logic [2:0] STATUS_MANUAL = 3'd7;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_ARM        = 4'd1,
        OP_FIRE       = 4'd2,
        OP_DISARM     = 4'd3,
        OP_MANUAL_ON  = 4'd4,
        OP_MANUAL_OFF = 4'd5,
        OP_MAGNET_ON  = 4'd6,
        OP_MAGNET_OFF = 4'd7,
        OP_MOVE       = 4'd8
    } opcode_t;

    typedef enum logic [1:0] {
        DRV_STOP = 2'd0,
        DRV_FWD  = 2'd1,
        DRV_BWD  = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        REG_ENGAGE_LIMIT  = 2'd0,
        REG_RETRACT_LIMIT = 2'd1,
        REG_PAUSE_TICKS   = 2'd2,
        REG_FIRE_HOLD     = 2'd3
    } reg_idx_t;

    localparam int ERR_ARM      = 0;
    localparam int ERR_PULLBACK = 1;
    localparam int ERR_RETAIN   = 2;

    typedef struct packed {
        logic [CFG_W-1:0] engage_limit;
        logic [CFG_W-1:0] retract_limit;
        logic [CFG_W-1:0] pause_ticks;
        logic             fire_hold;
    } cfg_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic       switch_a;
        logic       switch_b;
        logic [1:0] move_cmd;
    } in_item_t;

    typedef struct packed {
        logic       move_blocked;
        logic       active;
        logic [2:0] error_flags;
        logic [1:0] drive_cmd;
        logic       ready_led;
        logic       magnet_on;
        logic [2:0] status;
    } result_t;

endpackage

[hw/rtl/aafs_cfg.sv]
`timescale 1ns / 1ps

module aafs_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aafs_pkg::APB_AW-1:0]  paddr,
    input  logic [aafs_pkg::APB_DW-1:0]  pwdata,
    output logic [aafs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output aafs_pkg::cfg_t               cfg
);
    import aafs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_ENGAGE_LIMIT:  cfg_next.engage_limit  = pwdata[CFG_W-1:0];
                REG_RETRACT_LIMIT: cfg_next.retract_limit = pwdata[CFG_W-1:0];
                REG_PAUSE_TICKS:   cfg_next.pause_ticks   = pwdata[CFG_W-1:0];
                REG_FIRE_HOLD:     cfg_next.fire_hold     = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENGAGE_LIMIT:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.engage_limit};
            REG_RETRACT_LIMIT: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.retract_limit};
            REG_PAUSE_TICKS:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_reg.pause_ticks};
            REG_FIRE_HOLD:     prdata = {{(APB_DW-1){1'b0}}, cfg_reg.fire_hold};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.engage_limit  <= ENGAGE_LIMIT_RST;
            cfg_reg.retract_limit <= RETRACT_LIMIT_RST;
            cfg_reg.pause_ticks   <= PAUSE_TICKS_RST;
            cfg_reg.fire_hold     <= FIRE_HOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/aafs_core.sv]
`timescale 1ns / 1ps

module aafs_core #(
    parameter int TIMER_BITS = aafs_pkg::TIMER_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  aafs_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  aafs_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output aafs_pkg::result_t  out_item
);
    import aafs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // input stage
    logic     in_valid_reg;
    in_item_t in_item_reg;
    // result stage
    logic     out_valid_reg;
    result_t  out_item_reg;
    result_t  out_item_next;
    logic     advance;

    // sequencer state
    seq_state_t            state_reg, state_next;
    logic                  manual_reg, manual_next;
    logic                  arm_pend_reg, arm_pend_next;
    logic                  fire_pend_reg, fire_pend_next;
    logic                  reopen_reg, reopen_next;
    logic                  magnet_reg, magnet_next;
    logic                  ready_reg, ready_next;
    drive_t                drive_reg, drive_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [2:0]            error_reg, error_next;
    logic                  last_a_reg, last_a_next;
    logic                  last_b_reg, last_b_next;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_ext;
    logic                  over_arm, over_pullback, over_pause;
    drive_t                move_drv;
    logic                  blocked;
    logic                  go_idle;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign elapsed_inc   = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign elapsed_ext   = CMP_W'(elapsed_inc);
    assign over_arm      = elapsed_ext > CMP_W'(cfg.engage_limit);
    assign over_pullback = elapsed_ext > CMP_W'(cfg.retract_limit);
    assign over_pause    = elapsed_ext > CMP_W'(cfg.pause_ticks);

    always_comb begin
        case (in_item_reg.move_cmd)
            DRV_FWD: move_drv = DRV_FWD;
            DRV_BWD: move_drv = DRV_BWD;
            default: move_drv = DRV_STOP;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        manual_next    = manual_reg;
        arm_pend_next  = arm_pend_reg;
        fire_pend_next = fire_pend_reg;
        reopen_next    = reopen_reg;
        magnet_next    = magnet_reg;
        ready_next     = ready_reg;
        drive_next     = drive_reg;
        elapsed_next   = elapsed_reg;
        error_next     = error_reg;
        last_a_next    = last_a_reg;
        last_b_next    = last_b_reg;
        blocked        = 1'b0;
        go_idle        = 1'b0;

        unique case (opcode_t'(in_item_reg.opcode))
            OP_TICK: begin
                last_a_next = in_item_reg.switch_a;
                last_b_next = in_item_reg.switch_b;
                if (manual_reg) begin
                    ready_next = 1'b0;
                end else begin
                    elapsed_next = elapsed_inc;
                    unique case (state_reg)
                        ST_IDLE: begin
                            if (arm_pend_reg) begin
                                arm_pend_next = 1'b0;
                                magnet_next   = 1'b1;
                                drive_next    = DRV_FWD;
                                state_next    = ST_ENGAGE;
                            end else begin
                                go_idle = 1'b1;
                            end
                        end
                        ST_ENGAGE: begin
                            if (in_item_reg.switch_a) begin
                                drive_next = DRV_STOP;
                                state_next = ST_PAUSE;
                            end else if (over_arm) begin
                                error_next[ERR_ARM] = 1'b1;
                            end
                        end
                        ST_PAUSE: begin
                            if (over_pause) begin
                                drive_next = DRV_BWD;
                                state_next = ST_PULLBACK;
                            end
                        end
                        ST_PULLBACK: begin
                            if (in_item_reg.switch_b) begin
                                drive_next = DRV_STOP;
                                ready_next = 1'b1;
                                state_next = ST_ARMED;
                            end else if (over_pullback) begin
                                error_next[ERR_PULLBACK] = 1'b1;
                            end
                        end
                        ST_ARMED: begin
                            if (!in_item_reg.switch_a) begin
                                error_next[ERR_RETAIN] = 1'b1;
                            end
                            if (fire_pend_reg) begin
                                fire_pend_next = 1'b0;
                                magnet_next    = 1'b0;
                                ready_next     = 1'b0;
                                state_next     = cfg.fire_hold ? ST_HOLD : ST_FIRING;
                            end
                        end
                        ST_HOLD: begin
                            if (!in_item_reg.switch_a) begin
                                reopen_next = 1'b1;
                                drive_next  = DRV_FWD;
                            end else if (reopen_reg) begin
                                reopen_next = 1'b0;
                                state_next  = ST_IDLE;
                                go_idle     = 1'b1;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                            go_idle    = 1'b1;
                        end
                    endcase
                end
            end
            OP_ARM: begin
                if (!manual_reg && state_reg == ST_IDLE) begin
                    arm_pend_next = 1'b1;
                end
            end
            OP_FIRE: begin
                if (!manual_reg && state_reg == ST_ARMED) begin
                    fire_pend_next = 1'b1;
                end
            end
            OP_DISARM: begin
                state_next = ST_IDLE;
                go_idle    = 1'b1;
            end
            OP_MANUAL_ON: begin
                if (!manual_reg) begin
                    manual_next = 1'b1;
                    go_idle     = 1'b1;
                end
            end
            OP_MANUAL_OFF: begin
                if (manual_reg) begin
                    manual_next = 1'b0;
                    state_next  = ST_IDLE;
                    go_idle     = 1'b1;
                end
            end
            OP_MAGNET_ON: begin
                if (manual_reg) begin
                    magnet_next = 1'b1;
                end
            end
            OP_MAGNET_OFF: begin
                if (manual_reg) begin
                    magnet_next = 1'b0;
                end
            end
            OP_MOVE: begin
                if (!manual_reg) begin
                    blocked = 1'b1;
                end else if (move_drv == DRV_BWD && last_b_reg) begin
                    blocked = 1'b1;
                end else if (move_drv == DRV_FWD && last_a_reg) begin
                    blocked = 1'b1;
                end else begin
                    drive_next = move_drv;
                end
            end
            default: begin
                blocked = 1'b0;
            end
        endcase

        if (go_idle) begin
            drive_next     = DRV_STOP;
            magnet_next    = 1'b0;
            ready_next     = 1'b0;
            arm_pend_next  = 1'b0;
            fire_pend_next = 1'b0;
            error_next     = '0;
        end

        // any state change restarts the timer
        if (state_next != state_reg) begin
            elapsed_next = '0;
        end

        out_item_next.status       = manual_next ? STATUS_MANUAL : state_next;
        out_item_next.magnet_on    = magnet_next;
        out_item_next.ready_led    = ready_next;
        out_item_next.drive_cmd    = drive_next;
        out_item_next.error_flags  = error_next;
        out_item_next.active       = !manual_next && state_next != ST_IDLE
                                     && state_next != ST_FIRING;
        out_item_next.move_blocked = blocked;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            manual_reg    <= 1'b0;
            arm_pend_reg  <= 1'b0;
            fire_pend_reg <= 1'b0;
            reopen_reg    <= 1'b0;
            magnet_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            drive_reg     <= DRV_STOP;
            elapsed_reg   <= '0;
            error_reg     <= '0;
            last_a_reg    <= 1'b0;
            last_b_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                manual_reg    <= manual_next;
                arm_pend_reg  <= arm_pend_next;
                fire_pend_reg <= fire_pend_next;
                reopen_reg    <= reopen_next;
                magnet_reg    <= magnet_next;
                ready_reg     <= ready_next;
                drive_reg     <= drive_next;
                elapsed_reg   <= elapsed_next;
                error_reg     <= error_next;
                last_a_reg    <= last_a_next;
                last_b_reg    <= last_b_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_item_reg <= in_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

[hw/rtl/actuator_arm_fire_sequencer.sv]
`timescale 1ns / 1ps

// actuator arm / fire sequencer
// s_ channel: one request per millisecond tick or command; opcode on s_tuser,
//   switch levels and manual move code on s_tdata
// m_ channel: exactly one result request per input request, in order
// apb port: engage limit at 0x0, retract limit at 0x4, pause_ticks at 0x8,
//   fire hold at 0xc; write only while no request is in flight
// path: an accepted request passes the input register, then the result register, to m_
// throughput: one request per cycle while m_tready stays high, set by the
//   combinational next-state update between the input and result registers
// reset: sequencer idle, outputs off, timer and error bits clear, timeouts
//   1000 ticks, pause 500 ticks, hold after fire off
// stall: a held result keeps m_tdata; the input register still takes one
//   more request, then s_tready drops until m_tready returns
module actuator_arm_fire_sequencer #(
    parameter int TIMER_BITS = aafs_pkg::TIMER_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // switch_a, switch_b, move_cmd[1:0]
    input  logic [3:0]                  s_tuser,   // opcode[3:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // status[2:0], magnet_on, ready_led,
                                                   // drive_cmd[1:0], error_flags[2:0],
                                                   // active, move_blocked
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aafs_pkg::APB_AW-1:0] paddr,
    input  logic [aafs_pkg::APB_DW-1:0] pwdata,
    output logic [aafs_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import aafs_pkg::*;

    cfg_t     cfg;
    in_item_t in_item;
    result_t  out_item;

    assign in_item.opcode   = s_tuser;
    assign in_item.switch_a = s_tdata[0];
    assign in_item.switch_b = s_tdata[1];
    assign in_item.move_cmd = s_tdata[3:2];

    assign m_tdata = {4'b0000, out_item};

    aafs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aafs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    ap_ready_only_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_item.ready_led == (out_item.status == ST_ARMED)))
        else $error("ready led does not track armed state");

    ap_active_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_item.active == (out_item.status != ST_IDLE
            && out_item.status != ST_FIRING && out_item.status != STATUS_MANUAL)))
        else $error("active flag disagrees with status");

    ap_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_item.status == ST_IDLE) |->
            (out_item.drive_cmd == DRV_STOP && !out_item.magnet_on
             && out_item.error_flags == 3'b000))
        else $error("idle with drive, magnet or error set");

endmodule
